### sv/brf_pkg.sv
// shared constants, request codes and state type for the byte ring fifo
package brf_pkg;

  // default sizing handed to the top level parameters
  localparam int DEPTH_LOG2_DEF  = 10;
  localparam int MAX_REQUEST_DEF = 64;

  // fixed field widths of the channels
  localparam int TYPE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 11;
  localparam int CAP_W   = 4;

  // capacity register reset value and burst counter ceiling
  localparam logic [CAP_W-1:0]   CAP_LOG2_RESET = 4'd10;
  localparam logic [COUNT_W-1:0] BURST_MAX      = 11'd2047;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_WRITE   = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_READ    = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_PEEK    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DISCARD = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_CLEAR   = 3'd4;

  // sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } brf_state_t;

endpackage

### sv/brf_if.sv
// channel interfaces: request, result and capacity configuration

// request channel
interface brf_req_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [BYTE_W-1:0] data_byte;
  logic              burst_end;
  logic [LEN_W-1:0]  request_length;

  modport source (output valid, req_type, data_byte, burst_end, request_length,
                  input ready);
  modport sink   (input valid, req_type, data_byte, burst_end, request_length,
                  output ready);
endinterface

// result channel
interface brf_res_if import brf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [COUNT_W-1:0] done_count;
  logic               run_last;
  logic [COUNT_W-1:0] fill_level;
  logic [COUNT_W-1:0] space_left;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, out_byte, done_count, run_last, fill_level,
                  space_left, is_empty, is_full, input ready);
  modport sink   (input valid, out_byte, done_count, run_last, fill_level,
                  space_left, is_empty, is_full, output ready);
endinterface

// capacity register write channel
interface brf_cfg_if import brf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_log2;

  modport source (output valid, capacity_log2, input ready);
  modport sink   (input valid, capacity_log2, output ready);
endinterface

### sv/byte_ring_fifo.sv
// byte ring fifo: counters, read sequencer and byte store
//
//  channel | dir | transaction
//  --------+-----+-------------------------------------------------------------
//  cfg     | in  | capacity_log2 register write, always ready
//  req     | in  | one request: write byte, read, peek, discard or clear
//  res     | out | one result: byte, done count, last flag, fill/space status
//
// A discard, clear or empty read/peek gives one result, a write at burst_end.
// A read or peek of n bytes runs in order: the accepting cycle, a registered
// store read, then one byte per unstalled cycle through the single read port.
// Reset clears both counters, the burst count and the sequencer; the capacity
// register returns to 10. The store holds no reset value.
// A stalled result holds the sequencer; the store output register keeps one
// byte in hand so no byte is lost or read twice.
module byte_ring_fifo import brf_pkg::*; #(
  parameter int DEPTH_LOG2  = DEPTH_LOG2_DEF,
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic      clk,
  input  logic      rst,
  brf_cfg_if.sink   cfg,
  brf_req_if.sink   req,
  brf_res_if.source res
);

  localparam int DEPTH = 1 << DEPTH_LOG2;
  localparam int CW    = DEPTH_LOG2 + 1;
  localparam int CMPW  = (CW > LEN_W) ? CW : LEN_W;
  localparam int LGR   = $clog2(DEPTH_LOG2 + 1);
  localparam int LGW   = (LGR > CAP_W) ? LGR : CAP_W;

  // registers
  brf_state_t          state;
  brf_state_t          state_next;
  logic [CAP_W-1:0]    cap_lg;
  logic [CW-1:0]       wr_cnt;
  logic [CW-1:0]       rd_cnt;
  logic [CW-1:0]       wr_cnt_next;
  logic [CW-1:0]       rd_cnt_next;
  logic [COUNT_W-1:0]  burst_acc;
  logic [COUNT_W-1:0]  burst_acc_next;
  logic [CW-1:0]       iss_cnt;
  logic [LEN_W-1:0]    iss_left;
  logic [LEN_W-1:0]    out_left;
  logic [LEN_W-1:0]    run_done;
  logic                pend;
  logic [BYTE_W-1:0]   mem_q;
  logic [BYTE_W-1:0]   mem [DEPTH];

  logic                res_valid;
  logic [BYTE_W-1:0]   res_byte;
  logic [COUNT_W-1:0]  res_done;
  logic                res_last;
  logic [COUNT_W-1:0]  res_fill;
  logic [COUNT_W-1:0]  res_space;
  logic                res_empty;
  logic                res_full;

  // combinational
  logic                out_free;
  logic                acc;
  logic                mem_re;
  logic                load_rd;
  logic                emit;
  logic [COUNT_W-1:0]  emit_done;
  logic                mem_we;
  logic                start_run;
  logic [LGW-1:0]      lg_ext;
  logic [LGW-1:0]      lg_eff;
  logic [CW-1:0]       cap_bytes;
  logic [CW-1:0]       addr_mask;
  logic [CW-1:0]       fill_cur;
  logic [CW-1:0]       space_cur;
  logic [CW-1:0]       fill_nx;
  logic [CW-1:0]       space_nx;
  logic [LEN_W-1:0]    len_clamp;
  logic [LEN_W-1:0]    n_cur;
  logic [DEPTH_LOG2-1:0] wr_addr;
  logic [DEPTH_LOG2-1:0] rd_addr;

  // free space from a fill level, saturating at zero
  function automatic logic [CW-1:0] space_of(input logic [CW-1:0] f,
                                              input logic [CW-1:0] c);
    space_of = (f >= c) ? '0 : (c - f);
  endfunction

  // effective capacity and address mask
  always_comb begin
    lg_ext = LGW'(cap_lg);
    if (lg_ext == '0) begin
      lg_eff = LGW'(1);
    end else if (lg_ext > LGW'(DEPTH_LOG2)) begin
      lg_eff = LGW'(DEPTH_LOG2);
    end else begin
      lg_eff = lg_ext;
    end
  end
  assign cap_bytes = CW'(1) << lg_eff;
  assign addr_mask = cap_bytes - CW'(1);

  // current status and request length
  assign fill_cur  = wr_cnt - rd_cnt;
  assign space_cur = space_of(fill_cur, cap_bytes);
  assign len_clamp = (req.request_length > LEN_W'(MAX_REQUEST)) ?
                     LEN_W'(MAX_REQUEST) : req.request_length;
  assign n_cur     = (CMPW'(fill_cur) < CMPW'(len_clamp)) ?
                     LEN_W'(fill_cur) : len_clamp;

  // handshake and read path controls
  assign out_free = !res_valid || res.ready;
  assign acc      = req.valid && req.ready;

  always_comb begin
    req.ready = 1'b0;
    mem_re    = 1'b0;
    load_rd   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = out_free;
      end
      ST_READ: begin
        load_rd = pend && out_free;
        mem_re  = (iss_left != '0) && (!pend || load_rd);
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_run) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (load_rd && (out_left == LEN_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request decode: counter updates and single-result requests
  always_comb begin
    wr_cnt_next    = wr_cnt;
    rd_cnt_next    = rd_cnt;
    burst_acc_next = burst_acc;
    mem_we         = 1'b0;
    emit           = 1'b0;
    emit_done      = '0;
    start_run      = 1'b0;
    if (acc) begin
      case (req.req_type)
        REQ_WRITE: begin
          if (space_cur != '0) begin
            mem_we      = 1'b1;
            wr_cnt_next = wr_cnt + CW'(1);
            if (burst_acc != BURST_MAX) begin
              burst_acc_next = burst_acc + COUNT_W'(1);
            end
          end
          if (req.burst_end) begin
            emit           = 1'b1;
            emit_done      = burst_acc_next;
            burst_acc_next = '0;
          end
        end
        REQ_READ, REQ_PEEK: begin
          if (n_cur == '0) begin
            emit = 1'b1;
          end else begin
            start_run = 1'b1;
            if (req.req_type == REQ_READ) begin
              rd_cnt_next = rd_cnt + CW'(n_cur);
            end
          end
        end
        REQ_DISCARD: begin
          rd_cnt_next = rd_cnt + CW'(n_cur);
          emit        = 1'b1;
          emit_done   = COUNT_W'(n_cur);
        end
        REQ_CLEAR: begin
          wr_cnt_next = '0;
          rd_cnt_next = '0;
          emit        = 1'b1;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
  end

  // status after the request
  assign fill_nx  = wr_cnt_next - rd_cnt_next;
  assign space_nx = space_of(fill_nx, cap_bytes);

  // store addresses
  assign wr_addr = wr_cnt[DEPTH_LOG2-1:0] & addr_mask[DEPTH_LOG2-1:0];
  assign rd_addr = iss_cnt[DEPTH_LOG2-1:0] & addr_mask[DEPTH_LOG2-1:0];

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= req.data_byte;
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  // capacity register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_lg <= CAP_LOG2_RESET;
    end else if (cfg.valid) begin
      cap_lg <= cfg.capacity_log2;
    end
  end

  // counters and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_cnt    <= '0;
      rd_cnt    <= '0;
      burst_acc <= '0;
      iss_left  <= '0;
      out_left  <= '0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      wr_cnt    <= wr_cnt_next;
      rd_cnt    <= rd_cnt_next;
      burst_acc <= burst_acc_next;
      if (start_run) begin
        iss_left <= n_cur;
        out_left <= n_cur;
      end else begin
        if (mem_re) begin
          iss_left <= iss_left - LEN_W'(1);
        end
        if (load_rd) begin
          out_left <= out_left - LEN_W'(1);
        end
      end
      if (mem_re) begin
        pend <= 1'b1;
      end else if (load_rd) begin
        pend <= 1'b0;
      end
    end
  end

  // read run payload: issue address and byte count
  always_ff @(posedge clk) begin
    if (start_run) begin
      iss_cnt  <= rd_cnt;
      run_done <= n_cur;
    end else if (mem_re) begin
      iss_cnt <= iss_cnt + CW'(1);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit || load_rd) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit || load_rd) begin
      res_byte  <= load_rd ? mem_q : '0;
      res_done  <= load_rd ? COUNT_W'(run_done) : emit_done;
      res_last  <= load_rd ? (out_left == LEN_W'(1)) : 1'b1;
      res_fill  <= COUNT_W'(fill_nx);
      res_space <= COUNT_W'(space_nx);
      res_empty <= (fill_nx == '0);
      res_full  <= (space_nx == '0);
    end
  end

  assign res.valid      = res_valid;
  assign res.out_byte   = res_byte;
  assign res.done_count = res_done;
  assign res.run_last   = res_last;
  assign res.fill_level = res_fill;
  assign res.space_left = res_space;
  assign res.is_empty   = res_empty;
  assign res.is_full    = res_full;

endmodule
